// File: rtl/core/lpc_pkg.sv
// lpc_pkg: shared constants and types for the LRU page cache lookup.
// Used by lpc_cell and lru_page_cache_lookup; depends on nothing else.
package lpc_pkg;

   localparam int SLOTS       = 64;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int FILE_W      = 16;
   localparam int PAGE_W      = 52;
   localparam int CAP_W       = 7;
   localparam int OUT_SLOT_W  = 6;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_PAD_W   = REQ_TDATA_W - FILE_W - PAGE_W;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_PAD_W   = RSP_TDATA_W - OUT_SLOT_W - FILE_W - PAGE_W;
   localparam int RSP_TUSER_W = 2;

   typedef struct packed {
      logic [FILE_W-1:0] file;
      logic [PAGE_W-1:0] page;
   } lpc_key_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      lpc_key_type       key;
   } lpc_entry_type;

endpackage

// File: rtl/core/lpc_cell.sv
// lpc_cell: one recency position of the LRU chain; holds a page tag and its frame slot.
// Depends on lpc_pkg. Takes its upstream neighbor's entry when shifted.
module lpc_cell
   import lpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          shift,
   input  lpc_entry_type up_entry,
   input  lpc_key_type   req_key,
   output lpc_entry_type entry,
   output logic          match
);

   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] slot_ff;
   lpc_key_type       key_ff;
   logic              match_ff, match_in;

   assign valid_in = shift ? up_entry.valid : valid_ff;
   assign match_in = valid_ff && (key_ff == req_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         slot_ff <= up_entry.slot;
         key_ff  <= up_entry.key;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.slot  = slot_ff;
   assign entry.key   = key_ff;
   assign match       = match_ff;

endmodule

// File: rtl/core/lru_page_cache_lookup.sv
// lru_page_cache_lookup: LRU page cache lookup over a chain of recency-ordered cells.
// Depends on lpc_pkg and lpc_cell.
//
//   channel | dir | handshake              | word
//   --------+-----+------------------------+-------------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata: file_number, page_number
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: frame_slot, evicted_file/page;
//           |     |                        | tuser: hit, evicted
//   csr     | in  | csr_valid/csr_ready    | capacity_in_use
//
// Each word passes a compare state (tag compare in every cell, registered match
// bits) and an update state, where cells up to the hit, victim or free position
// take their neighbor's entry. The next word is taken in the update cycle.
// Reset clears cell valid bits and resident count, and sets capacity to 64.
// A stalled rsp holds the update cycle; req_tready drops until it drains.
module lru_page_cache_lookup
   import lpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // file_number, page_number, pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // frame_slot, evicted_file, evicted_page, pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // hit, evicted
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CAP_W-1:0]       csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_UPD  = 3'b100
   } lpc_state_type;

   lpc_state_type state_ff, state_in;

   lpc_key_type       req_key_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   lpc_entry_type     victim_ff, victim_in;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_evicted_ff;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff;
   logic [FILE_W-1:0]     rsp_efile_ff;
   logic [PAGE_W-1:0]     rsp_epage_ff;

   lpc_entry_type     entry_vec [SLOTS];
   logic [SLOTS-1:0]  match_vec;
   logic [SLOTS-1:0]  valid_vec;
   logic [SLOTS-1:0]  shift_vec;

   logic              upd_fire, req_fire;
   logic [CNT_W-1:0]  eff_cap;
   logic              hit, evict;
   logic [SLOT_W-1:0] hit_pos, hit_slot, pos, new_slot, vic_idx;
   lpc_entry_type     new_entry;

   // ---------------- handshakes ----------------
   assign upd_fire   = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) || upd_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------- decision logic ----------------
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > SLOTS) begin
         eff_cap = CNT_W'(SLOTS);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   always_comb begin
      hit_pos  = '0;
      hit_slot = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (match_vec[k]) begin
            hit_pos  = hit_pos | SLOT_W'(k);
            hit_slot = hit_slot | entry_vec[k].slot;
         end
      end
   end

   assign hit     = |match_vec;
   assign evict   = !hit && (count_ff >= eff_cap) && (count_ff != '0);
   assign vic_idx = SLOT_W'(count_ff - CNT_W'(1));

   always_comb begin
      if (hit) begin
         pos      = hit_pos;
         new_slot = hit_slot;
      end else if (evict) begin
         pos      = vic_idx;
         new_slot = victim_ff.slot;
      end else begin
         pos      = SLOT_W'(count_ff);
         new_slot = SLOT_W'(count_ff);
      end
   end

   assign new_entry.valid = 1'b1;
   assign new_entry.slot  = new_slot;
   assign new_entry.key   = req_key_ff;

   // least recent entry sits at position count-1
   assign victim_in = entry_vec[vic_idx];
   assign count_in  = (upd_fire && !hit && !evict) ? count_ff + CNT_W'(1) : count_ff;

   // ---------------- cell chain ----------------
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      assign shift_vec[k] = upd_fire && (SLOT_W'(k) <= pos);
      assign valid_vec[k] = entry_vec[k].valid;
      if (k == 0) begin : g_head
         lpc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift_vec[k]),
            .up_entry (new_entry),
            .req_key  (req_key_ff),
            .entry    (entry_vec[k]),
            .match    (match_vec[k])
         );
      end else begin : g_body
         lpc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift_vec[k]),
            .up_entry (entry_vec[k-1]),
            .req_key  (req_key_ff),
            .entry    (entry_vec[k]),
            .match    (match_vec[k])
         );
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_fire) state_in = req_fire ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(64);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) cap_ff <= csr_data;
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      victim_ff <= victim_in;
      if (req_fire) begin
         req_key_ff.file <= req_tdata[FILE_W-1:0];
         req_key_ff.page <= req_tdata[FILE_W+PAGE_W-1:FILE_W];
      end
      if (upd_fire) begin
         rsp_hit_ff     <= hit;
         rsp_evicted_ff <= evict;
         rsp_slot_ff    <= OUT_SLOT_W'(new_slot);
         rsp_efile_ff   <= evict ? victim_ff.key.file : '0;
         rsp_epage_ff   <= evict ? victim_ff.key.page : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_epage_ff, rsp_efile_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_evicted_ff, rsp_hit_ff};

   // ---------------- assertions ----------------
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD |-> $onehot0(match_vec))
      else $error("more than one cell matched the request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("resident count beyond slot count");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("valid cells disagree with resident count");

   a_evict_keeps_count: assert property (@(posedge clock) disable iff (reset)
      upd_fire && evict |=> count_ff == $past(count_ff))
      else $error("eviction changed resident count");

endmodule
